// ===== sv/i2cmbe_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
// No dependencies; imported by the top level and the sequencer step logic.
package i2cmbe_pkg;

    // Command codes carried in the kind field
    localparam logic [2:0] KIND_RECOVER = 3'd1;
    localparam logic [2:0] KIND_START   = 3'd2;
    localparam logic [2:0] KIND_STOP    = 3'd3;
    localparam logic [2:0] KIND_WRITE   = 3'd4;
    localparam logic [2:0] KIND_READ    = 3'd5;

    localparam logic [15:0] DELAY_RESET = 16'd20;
    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

    // Line sequencer phases, one-hot
    typedef enum logic [16:0] {
        PH_IDLE = 17'h00001,
        PH_S1   = 17'h00002,
        PH_S2   = 17'h00004,
        PH_T1   = 17'h00008,
        PH_T2   = 17'h00010,
        PH_T3   = 17'h00020,
        PH_WLO  = 17'h00040,
        PH_WHI  = 17'h00080,
        PH_WALO = 17'h00100,
        PH_WAHI = 17'h00200,
        PH_RHI  = 17'h00400,
        PH_RLO  = 17'h00800,
        PH_RA1  = 17'h01000,
        PH_RA2  = 17'h02000,
        PH_V1   = 17'h04000,
        PH_VLO  = 17'h08000,
        PH_VHI  = 17'h10000
    } phase_t;

    // One input item
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] tx_byte;
        logic       rd_ack;
        logic       sda_in;
    } item_t;

    // Sequencer state carried from tick to tick
    typedef struct packed {
        phase_t      phase;
        logic [3:0]  bit_count;
        logic [7:0]  shift_byte;
        logic [15:0] delay_count;
        logic        scl_drive;
        logic        sda_drive;
        logic        ack_flag;
        logic        ack_to_send;
        logic [7:0]  rx_last;
    } seq_state_t;

endpackage

// ===== sv/i2c_master_bit_engine_core.sv =====
// I2C master bit engine, top level: input register, sequencer state, result register.
// Depends on i2cmbe_pkg and i2cmbe_step.
//
// Usage: each item on the s_ channel is one tick of the line sequencer. While
// the engine is idle a tick may carry a command in s_kind (recover, start,
// stop, write byte, read byte); s_sda_in carries the sampled SDA level. Each
// tick yields exactly one item on the m_ channel with the SCL/SDA drives,
// busy and done flags, the last received byte and the last ACK sample.
// cfg_wr_en/cfg_wr_data load the quarter-bit delay in ticks (zero acts as 1).
// Pipeline: an item is held in the input register and is processed as it
// moves into the result register, which raises m_valid.
// Throughput: one item per cycle while m_ready does not stall the results.
// A stalled m_ready holds the result; one more item waits in the input
// register, then s_ready drops. Reset (aresetn low, synchronous) empties both
// registers, releases both lines, idles the sequencer and sets the delay to 20.
module i2c_master_bit_engine_core import i2cmbe_pkg::*; #(
    parameter int RECOVERY_PULSES = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [7:0]  s_tx_byte,
    input  logic        s_rd_ack,
    input  logic        s_sda_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_level,
    output logic        m_sda_level,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic [7:0]  m_rx_byte,
    output logic        m_ack_seen
);

    logic        in_valid_reg;
    item_t       in_item_reg;
    logic [15:0] delay_ticks_reg;
    seq_state_t  state_reg;
    seq_state_t  state_next;
    logic        step_done;
    logic        advance;

    logic        out_valid_reg;
    logic        scl_reg;
    logic        sda_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [7:0]  rx_reg;
    logic        ack_reg;

    // The held item moves on when the result register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Delay register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_ticks_reg <= DELAY_RESET;
        end else if (cfg_wr_en) begin
            delay_ticks_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= '{kind: s_kind, tx_byte: s_tx_byte,
                             rd_ack: s_rd_ack, sda_in: s_sda_in};
        end
    end

    i2cmbe_step #(
        .RECOVERY_PULSES(RECOVERY_PULSES)
    ) u_step (
        .cur        (state_reg),
        .item       (in_item_reg),
        .delay_ticks(delay_ticks_reg),
        .nxt        (state_next),
        .done       (step_done)
    );

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_IDLE, bit_count: '0, shift_byte: '0,
                           delay_count: '0, scl_drive: 1'b1, sda_drive: 1'b1,
                           ack_flag: 1'b0, ack_to_send: 1'b0, rx_last: '0};
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            scl_reg  <= state_next.scl_drive;
            sda_reg  <= state_next.sda_drive;
            busy_reg <= (state_next.phase != PH_IDLE);
            done_reg <= step_done;
            rx_reg   <= state_next.rx_last;
            ack_reg  <= state_next.ack_flag;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_scl_level = scl_reg;
    assign m_sda_level = sda_reg;
    assign m_busy_res  = busy_reg;
    assign m_done_res  = done_reg;
    assign m_rx_byte   = rx_reg;
    assign m_ack_seen  = ack_reg;

endmodule

// ===== sv/i2cmbe_step.sv =====
// Next-state logic of the line sequencer: one tick in, updated state out.
// Depends on i2cmbe_pkg.
module i2cmbe_step import i2cmbe_pkg::*; #(
    parameter int RECOVERY_PULSES = 9
) (
    input  seq_state_t  cur,
    input  item_t       item,
    input  logic [15:0] delay_ticks,
    output seq_state_t  nxt,
    output logic        done
);

    localparam logic [4:0] PULSES = 5'(RECOVERY_PULSES);

    logic [15:0] delay_load;
    logic [15:0] cnt_dec;
    logic [3:0]  bc_inc;
    logic [4:0]  pulse_next;
    logic [7:0]  shift_w;

    // A zero delay register counts as one tick
    assign delay_load = (delay_ticks == '0) ? 16'd1 : delay_ticks;
    assign cnt_dec    = cur.delay_count - 16'd1;
    assign bc_inc     = cur.bit_count + 4'd1;
    assign pulse_next = {1'b0, cur.bit_count} + 5'd1;
    assign shift_w    = {cur.shift_byte[6:0], 1'b0};

    always_comb begin
        nxt  = cur;
        done = 1'b0;
        if (cur.phase == PH_IDLE) begin
            // Command launch: first line change and first delay
            case (item.kind)
                KIND_RECOVER: begin
                    nxt.sda_drive   = 1'b1;
                    nxt.scl_drive   = 1'b1;
                    nxt.phase       = PH_V1;
                    nxt.delay_count = delay_load;
                end
                KIND_START: begin
                    nxt.sda_drive   = 1'b1;
                    nxt.scl_drive   = 1'b1;
                    nxt.phase       = PH_S1;
                    nxt.delay_count = delay_load;
                end
                KIND_STOP: begin
                    nxt.sda_drive   = 1'b0;
                    nxt.phase       = PH_T1;
                    nxt.delay_count = delay_load;
                end
                KIND_WRITE: begin
                    nxt.shift_byte  = item.tx_byte;
                    nxt.bit_count   = '0;
                    nxt.sda_drive   = item.tx_byte[7];
                    nxt.phase       = PH_WLO;
                    nxt.delay_count = delay_load;
                end
                KIND_READ: begin
                    nxt.shift_byte  = '0;
                    nxt.bit_count   = '0;
                    nxt.ack_to_send = item.rd_ack;
                    nxt.sda_drive   = 1'b1;
                    nxt.scl_drive   = 1'b1;
                    nxt.phase       = PH_RHI;
                    nxt.delay_count = delay_load;
                end
                default: begin
                    nxt = cur;
                end
            endcase
        end else begin
            // Count down; on expiry take the next step of the sequence
            nxt.delay_count = cnt_dec;
            if (cnt_dec == '0) begin
                case (cur.phase)
                    PH_S1: begin
                        nxt.sda_drive   = 1'b0;
                        nxt.phase       = PH_S2;
                        nxt.delay_count = delay_load;
                    end
                    PH_S2: begin
                        nxt.scl_drive = 1'b0;
                        nxt.phase     = PH_IDLE;
                        done          = 1'b1;
                    end
                    PH_T1: begin
                        nxt.scl_drive   = 1'b1;
                        nxt.phase       = PH_T2;
                        nxt.delay_count = delay_load;
                    end
                    PH_T2: begin
                        nxt.sda_drive   = 1'b1;
                        nxt.phase       = PH_T3;
                        nxt.delay_count = delay_load;
                    end
                    PH_WLO: begin
                        nxt.scl_drive   = 1'b1;
                        nxt.phase       = PH_WHI;
                        nxt.delay_count = delay_load;
                    end
                    PH_WHI: begin
                        nxt.scl_drive   = 1'b0;
                        nxt.shift_byte  = shift_w;
                        nxt.bit_count   = bc_inc;
                        nxt.delay_count = delay_load;
                        if (bc_inc < BITS_PER_BYTE) begin
                            nxt.sda_drive = shift_w[7];
                            nxt.phase     = PH_WLO;
                        end else begin
                            nxt.sda_drive = 1'b1;
                            nxt.phase     = PH_WALO;
                        end
                    end
                    PH_WALO: begin
                        nxt.scl_drive   = 1'b1;
                        nxt.phase       = PH_WAHI;
                        nxt.delay_count = delay_load;
                    end
                    PH_WAHI: begin
                        nxt.ack_flag  = ~item.sda_in;
                        nxt.scl_drive = 1'b0;
                        nxt.phase     = PH_IDLE;
                        done          = 1'b1;
                    end
                    PH_RHI: begin
                        nxt.shift_byte  = {cur.shift_byte[6:0], item.sda_in};
                        nxt.bit_count   = bc_inc;
                        nxt.scl_drive   = 1'b0;
                        nxt.phase       = PH_RLO;
                        nxt.delay_count = delay_load;
                    end
                    PH_RLO: begin
                        nxt.delay_count = delay_load;
                        if (cur.bit_count < BITS_PER_BYTE) begin
                            nxt.scl_drive = 1'b1;
                            nxt.phase     = PH_RHI;
                        end else begin
                            nxt.sda_drive = ~cur.ack_to_send;
                            nxt.phase     = PH_RA1;
                        end
                    end
                    PH_RA1: begin
                        nxt.scl_drive   = 1'b1;
                        nxt.phase       = PH_RA2;
                        nxt.delay_count = delay_load;
                    end
                    PH_RA2: begin
                        nxt.scl_drive = 1'b0;
                        nxt.sda_drive = 1'b1;
                        nxt.rx_last   = cur.shift_byte;
                        nxt.phase     = PH_IDLE;
                        done          = 1'b1;
                    end
                    PH_V1: begin
                        nxt.delay_count = delay_load;
                        if (!item.sda_in) begin
                            // SDA stuck low: clock it free
                            nxt.bit_count = '0;
                            nxt.scl_drive = 1'b0;
                            nxt.phase     = PH_VLO;
                        end else begin
                            nxt.sda_drive = 1'b0;
                            nxt.phase     = PH_T1;
                        end
                    end
                    PH_VLO: begin
                        nxt.scl_drive   = 1'b1;
                        nxt.phase       = PH_VHI;
                        nxt.delay_count = delay_load;
                    end
                    PH_VHI: begin
                        nxt.delay_count = delay_load;
                        if (pulse_next >= PULSES) begin
                            nxt.sda_drive = 1'b0;
                            nxt.phase     = PH_T1;
                        end else begin
                            nxt.bit_count = pulse_next[3:0];
                            nxt.scl_drive = 1'b0;
                            nxt.phase     = PH_VLO;
                        end
                    end
                    default: begin
                        // End of stop hold, or an unused code
                        nxt.phase = PH_IDLE;
                        done      = 1'b1;
                    end
                endcase
            end
        end
    end

endmodule

// ===== sv/i2cmbe_checker.sv =====
// Port-level checks for the I2C master bit engine, bound to the top level.
// Depends only on the top level's ports.
module i2cmbe_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_scl_level,
    input logic       m_sda_level,
    input logic       m_busy_res,
    input logic       m_done_res,
    input logic [7:0] m_rx_byte,
    input logic       m_ack_seen
);

    // A completing tick never reports busy
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_done_res && m_busy_res))
        else $error("done and busy both set");

    // With no result pending the engine can always take an item
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_scl_level)
            && $stable(m_sda_level) && $stable(m_busy_res) && $stable(m_done_res)
            && $stable(m_rx_byte) && $stable(m_ack_seen)))
        else $error("stalled result changed");

endmodule

bind i2c_master_bit_engine_core i2cmbe_checker u_i2cmbe_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_scl_level(m_scl_level),
    .m_sda_level(m_sda_level),
    .m_busy_res (m_busy_res),
    .m_done_res (m_done_res),
    .m_rx_byte  (m_rx_byte),
    .m_ack_seen (m_ack_seen)
);

// ===== dv/i2c_master_bit_engine_core_test.sv =====
// Self-checking testbench for i2c_master_bit_engine_core: drives line ticks and
// commands, tracks SCL/SDA sequencing in a cycle model and checks every result.
// Depends on i2cmbe_pkg and the RTL of the block only.
module i2c_master_bit_engine_core_test;
    import i2cmbe_pkg::*;

    // Kind values with no command behind them
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_RSVD_A = 3'd6;
    localparam logic [2:0] KIND_RSVD_B = 3'd7;

    localparam int RECOVER_PULSES = 9;
    localparam int MAX_GAP        = 40;
    localparam int QUIET_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 4;

    typedef enum {BUS_LOW, BUS_HIGH, BUS_RAND} bus_mode_t;

    // One result item as seen on the m_ side
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       ack;
    } line_result_t;

    // Cycle model of the line sequencer plus the queue of expected line states
    class bus_line_tracker;
        phase_t       phase;
        logic [3:0]   bit_cnt;
        logic [7:0]   shreg;
        logic [15:0]  dly_cnt;
        logic [15:0]  dly_reg;
        logic         scl;
        logic         sda;
        logic         ack_flag;
        logic         ack_pend;
        logic [7:0]   rx_last;
        line_result_t want_lines[$];
        int           errors;

        function new();
            phase    = PH_IDLE;
            bit_cnt  = '0;
            shreg    = '0;
            dly_cnt  = '0;
            dly_reg  = DELAY_RESET;
            scl      = 1'b1;
            sda      = 1'b1;
            ack_flag = 1'b0;
            ack_pend = 1'b0;
            rx_last  = '0;
            errors   = 0;
        endfunction

        function bit idle();
            return phase == PH_IDLE;
        endfunction

        function int pending();
            return want_lines.size();
        endfunction

        // Enter a phase and load the quarter-bit delay (zero acts as one)
        function void arm(phase_t p);
            phase   = p;
            dly_cnt = (dly_reg == '0) ? 16'd1 : dly_reg;
        endfunction

        function void begin_stop();
            sda = 1'b0;
            arm(PH_T1);
        endfunction

        // Delay ran out: next line change; returns 1 when the command is complete
        function bit expire(logic sda_bit);
            case (phase)
                PH_S1: begin
                    sda = 1'b0;
                    arm(PH_S2);
                end
                PH_S2: begin
                    scl = 1'b0;
                    return 1'b1;
                end
                PH_T1: begin
                    scl = 1'b1;
                    arm(PH_T2);
                end
                PH_T2: begin
                    sda = 1'b1;
                    arm(PH_T3);
                end
                PH_T3: return 1'b1;
                PH_WLO: begin
                    scl = 1'b1;
                    arm(PH_WHI);
                end
                PH_WHI: begin
                    scl     = 1'b0;
                    shreg   = shreg << 1;
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt < BITS_PER_BYTE) begin
                        sda = shreg[7];
                        arm(PH_WLO);
                    end else begin
                        sda = 1'b1;
                        arm(PH_WALO);
                    end
                end
                PH_WALO: begin
                    scl = 1'b1;
                    arm(PH_WAHI);
                end
                PH_WAHI: begin
                    ack_flag = (sda_bit == 1'b0);
                    scl      = 1'b0;
                    return 1'b1;
                end
                PH_RHI: begin
                    shreg   = {shreg[6:0], sda_bit};
                    bit_cnt = bit_cnt + 4'd1;
                    scl     = 1'b0;
                    arm(PH_RLO);
                end
                PH_RLO: begin
                    if (bit_cnt < BITS_PER_BYTE) begin
                        scl = 1'b1;
                        arm(PH_RHI);
                    end else begin
                        sda = ack_pend ? 1'b0 : 1'b1;
                        arm(PH_RA1);
                    end
                end
                PH_RA1: begin
                    scl = 1'b1;
                    arm(PH_RA2);
                end
                PH_RA2: begin
                    scl     = 1'b0;
                    sda     = 1'b1;
                    rx_last = shreg;
                    return 1'b1;
                end
                PH_V1: begin
                    // SDA stuck low: clock it free before the stop
                    if (sda_bit == 1'b0) begin
                        bit_cnt = '0;
                        scl     = 1'b0;
                        arm(PH_VLO);
                    end else begin
                        begin_stop();
                    end
                end
                PH_VLO: begin
                    scl = 1'b1;
                    arm(PH_VHI);
                end
                PH_VHI: begin
                    if (int'(bit_cnt) + 1 >= RECOVER_PULSES) begin
                        begin_stop();
                    end else begin
                        bit_cnt = bit_cnt + 4'd1;
                        scl     = 1'b0;
                        arm(PH_VLO);
                    end
                end
                default: return 1'b1;
            endcase
            return 1'b0;
        endfunction

        // Accepted tick: advance the model and queue the expected line state
        function void note_tick(item_t it);
            line_result_t r;
            bit           fin;
            fin = 1'b0;
            if (phase == PH_IDLE) begin
                case (it.kind)
                    KIND_RECOVER: begin
                        sda = 1'b1;
                        scl = 1'b1;
                        arm(PH_V1);
                    end
                    KIND_START: begin
                        sda = 1'b1;
                        scl = 1'b1;
                        arm(PH_S1);
                    end
                    KIND_STOP: begin_stop();
                    KIND_WRITE: begin
                        // SCL keeps its drive on the first change
                        shreg   = it.tx_byte;
                        bit_cnt = '0;
                        sda     = it.tx_byte[7];
                        arm(PH_WLO);
                    end
                    KIND_READ: begin
                        shreg    = '0;
                        bit_cnt  = '0;
                        ack_pend = it.rd_ack;
                        sda      = 1'b1;
                        scl      = 1'b1;
                        arm(PH_RHI);
                    end
                    default: ;
                endcase
            end else begin
                dly_cnt = dly_cnt - 16'd1;
                if (dly_cnt == '0) begin
                    if (expire(it.sda_in)) begin
                        phase = PH_IDLE;
                        fin   = 1'b1;
                    end
                end
            end
            r.scl  = scl;
            r.sda  = sda;
            r.busy = (phase != PH_IDLE);
            r.done = fin;
            r.rx   = rx_last;
            r.ack  = ack_flag;
            want_lines.push_back(r);
        endfunction

        function void check_field(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%02h, got 0x%02h", field, want, got);
                errors++;
            end
        endfunction

        function void check_lines(line_result_t got);
            line_result_t want;
            if (want_lines.size() == 0) begin
                $error("result item with no expectation waiting");
                errors++;
                return;
            end
            want = want_lines.pop_front();
            check_field("scl_level", 8'(want.scl), 8'(got.scl));
            check_field("sda_level", 8'(want.sda), 8'(got.sda));
            check_field("busy_res", 8'(want.busy), 8'(got.busy));
            check_field("done_res", 8'(want.done), 8'(got.done));
            check_field("rx_byte", want.rx, got.rx);
            check_field("ack_seen", 8'(want.ack), 8'(got.ack));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_kind;
    logic [7:0]  s_tx_byte;
    logic        s_rd_ack;
    logic        s_sda_in;
    logic        m_valid;
    logic        m_ready;
    logic        m_scl_level;
    logic        m_sda_level;
    logic        m_busy_res;
    logic        m_done_res;
    logic [7:0]  m_rx_byte;
    logic        m_ack_seen;

    bus_line_tracker board = new();
    int send_pct;
    int stall_pct;
    int quiet;

    i2c_master_bit_engine_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_tx_byte   (s_tx_byte),
        .s_rd_ack    (s_rd_ack),
        .s_sda_in    (s_sda_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_scl_level (m_scl_level),
        .m_sda_level (m_sda_level),
        .m_busy_res  (m_busy_res),
        .m_done_res  (m_done_res),
        .m_rx_byte   (m_rx_byte),
        .m_ack_seen  (m_ack_seen)
    );

    // Clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Result checker and quiet-cycle counter, sampled mid-cycle
    initial begin
        line_result_t got;
        forever begin
            @(negedge aclk);
            if (aresetn) begin
                if (m_valid && m_ready) begin
                    got.scl  = m_scl_level;
                    got.sda  = m_sda_level;
                    got.busy = m_busy_res;
                    got.done = m_done_res;
                    got.rx   = m_rx_byte;
                    got.ack  = m_ack_seen;
                    board.check_lines(got);
                end
                if ((s_valid && s_ready) || (m_valid && m_ready))
                    quiet = 0;
                else
                    quiet++;
            end
        end
    end

    // Watchdog
    initial begin
        while (quiet < QUIET_LIMIT) @(negedge aclk);
        $display("i2c_master_bit_engine_core: mismatch");
        $finish;
    end

    // 0: none, 1: sender idles, 2: receiver stalls, 3: both lightly
    function automatic void set_idling(int mode);
        case (mode)
            1: begin send_pct = 79; stall_pct = 0; end
            2: begin send_pct = 0; stall_pct = 79; end
            3: begin send_pct = 9; stall_pct = 9; end
            default: begin send_pct = 0; stall_pct = 0; end
        endcase
    endfunction

    function automatic logic pick_sda(bus_mode_t bus);
        case (bus)
            BUS_LOW:  return 1'b0;
            BUS_HIGH: return 1'b1;
            default:  return 1'($urandom);
        endcase
    endfunction

    // Offer one tick item after a random gap; returns at the accepting edge
    task automatic push_tick(input item_t it);
        int gap;
        bit taken;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_pct) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_kind     <= it.kind;
        s_tx_byte  <= it.tx_byte;
        s_rd_ack   <= it.rd_ack;
        s_sda_in   <= it.sda_in;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        board.note_tick(it);
    endtask

    // Issue a command, then tick until the sequencer is idle again.
    // Busy ticks sometimes carry commands, which must be ignored.
    task automatic run_cmd(input logic [2:0] kind, input logic [7:0] tx,
                           input logic ack, input bus_mode_t bus);
        item_t it;
        it.kind     = kind;
        it.tx_byte  = tx;
        it.rd_ack   = ack;
        it.sda_in   = pick_sda(bus);
        push_tick(it);
        while (!board.idle()) begin
            it.kind     = ($urandom_range(3) == 0) ? 3'($urandom_range(1, 7)) : KIND_NONE;
            it.tx_byte  = 8'($urandom);
            it.rd_ack   = 1'($urandom);
            it.sda_in   = pick_sda(bus);
            push_tick(it);
        end
    endtask

    // Hold off the sender until every expected result has come
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
    endtask

    task automatic load_delay(input logic [15:0] ticks);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        board.dly_reg = ticks;
    endtask

    task automatic directed_cmds();
        run_cmd(KIND_NONE, 8'h00, 1'b0, BUS_RAND);
        run_cmd(KIND_RSVD_A, 8'hFF, 1'b1, BUS_RAND);
        run_cmd(KIND_RSVD_B, 8'h5A, 1'b1, BUS_RAND);
        // write with SCL still released
        run_cmd(KIND_WRITE, 8'hFF, 1'b0, BUS_LOW);
        run_cmd(KIND_START, 8'h00, 1'b0, BUS_RAND);
        run_cmd(KIND_WRITE, 8'h00, 1'b1, BUS_HIGH);
        run_cmd(KIND_WRITE, 8'hA5, 1'b0, BUS_RAND);
        run_cmd(KIND_READ, 8'h00, 1'b1, BUS_RAND);
        run_cmd(KIND_READ, 8'hFF, 1'b0, BUS_HIGH);
        run_cmd(KIND_READ, 8'h3C, 1'b1, BUS_LOW);
        run_cmd(KIND_STOP, 8'h00, 1'b0, BUS_RAND);
        // recovery with SDA free, then with SDA stuck low
        run_cmd(KIND_RECOVER, 8'h00, 1'b0, BUS_HIGH);
        run_cmd(KIND_RECOVER, 8'h00, 1'b0, BUS_LOW);
        run_cmd(KIND_STOP, 8'h00, 1'b0, BUS_RAND);
    endtask

    // Mostly well-formed transfers: start, some bytes, stop or repeated start
    task automatic random_cmds(input int target);
        int issued;
        int xact;
        int nbytes;
        int pick;
        issued = 0;
        xact   = 0;
        while (issued < target) begin
            set_idling(xact % 4);
            pick = $urandom_range(9);
            if (pick == 0) begin
                pick = $urandom_range(2);
                run_cmd((pick == 0) ? KIND_NONE : ((pick == 1) ? KIND_RSVD_A : KIND_RSVD_B),
                        8'($urandom), 1'($urandom), BUS_RAND);
            end
            if (pick < 2) begin
                run_cmd(3'($urandom_range(KIND_RECOVER, KIND_READ)), 8'($urandom),
                        1'($urandom), BUS_RAND);
                issued++;
            end else begin
                run_cmd(KIND_START, 8'($urandom), 1'($urandom), BUS_RAND);
                nbytes = $urandom_range(1, 3);
                repeat (nbytes) begin
                    run_cmd($urandom_range(1) ? KIND_WRITE : KIND_READ, 8'($urandom),
                            1'($urandom), BUS_RAND);
                end
                issued += nbytes + 1;
                if ($urandom_range(4) != 0) begin
                    run_cmd(KIND_STOP, 8'($urandom), 1'($urandom), BUS_RAND);
                    issued++;
                end
            end
            xact++;
            if (xact % 6 == 0) settle();
        end
    endtask

    // Main sequence
    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_kind      = KIND_NONE;
        s_tx_byte   = '0;
        s_rd_ack    = 1'b0;
        s_sda_in    = 1'b1;
        quiet       = 0;
        set_idling(0);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset delay of 20: a stop leaves both lines released
        run_cmd(KIND_STOP, 8'h00, 1'b0, BUS_RAND);

        load_delay(16'd1);
        directed_cmds();

        load_delay(16'd0);
        random_cmds(15);
        load_delay(16'd2);
        random_cmds(10);
        load_delay(16'd3);
        random_cmds(6);

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0)
            $display("i2c_master_bit_engine_core: match");
        else
            $display("i2c_master_bit_engine_core: mismatch");
        $finish;
    end

endmodule
